### hw/rtl/pdcm_pkg.sv
// pdcm_pkg: shared types and constants for the pwm duty-cycle meter
// no dependencies; imported by every module of the block

package pdcm_pkg;

  localparam int TS_W    = 32;
  localparam int SUM_W   = 64;
  localparam int TALLY_W = 32;
  localparam int DUTY_W  = 14;
  // 10000 * sum needs 14 more bits than the sum
  localparam int ACC_W   = SUM_W + DUTY_W;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 14'd10000;

  // 10000 = 2^13 + 2^10 + 2^9 + 2^8 + 2^4, one term per multiply step
  localparam logic [2:0] MUL_STEPS = 3'd5;
  localparam logic [3:0] DIV_STEPS = 4'd14;

  localparam logic CMD_EDGE    = 1'b0;
  localparam logic CMD_HARVEST = 1'b1;
  localparam logic LVL_RISE    = 1'b1;

  // one harvest handed from the front to the divider
  typedef struct packed {
    logic [SUM_W-1:0] high_sum;
    logic [SUM_W-1:0] period_sum;
    logic             ok;
  } job_t;

  function automatic logic [3:0] mul_shift(input logic [2:0] step);
    logic [3:0] sh;
    case (step)
      3'd0:    sh = 4'd13;
      3'd1:    sh = 4'd10;
      3'd2:    sh = 4'd9;
      3'd3:    sh = 4'd8;
      3'd4:    sh = 4'd4;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

### hw/rtl/pdcm_front.sv
// pdcm_front: edge bookkeeping, window sums and harvest snapshot
// depends on pdcm_pkg

module pdcm_front
  import pdcm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic            in_command,
  input  logic            in_level,
  input  logic [TS_W-1:0] in_timestamp_us,
  input  logic            q_full,
  output logic            q_push,
  output job_t            q_job
);

  logic [TS_W-1:0]    last_rise_r, last_rise_nxt;
  logic [TS_W-1:0]    last_fall_r, last_fall_nxt;
  logic               rise_seen_r, rise_seen_nxt;
  logic [SUM_W-1:0]   hsum_r, hsum_nxt;
  logic [SUM_W-1:0]   psum_r, psum_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic               accept;
  logic [TS_W-1:0]    period_d;
  logic [TS_W-1:0]    high_d;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign q_push  = accept && (in_command == CMD_HARVEST);

  assign q_job.high_sum   = hsum_r;
  assign q_job.period_sum = psum_r;
  assign q_job.ok         = (tally_r != '0) && (psum_r != '0);

  // differences wrap modulo 2^32
  assign period_d = in_timestamp_us - last_rise_r;
  assign high_d   = last_fall_r - last_rise_r;

  always_comb begin
    last_rise_nxt = last_rise_r;
    last_fall_nxt = last_fall_r;
    rise_seen_nxt = rise_seen_r;
    hsum_nxt      = hsum_r;
    psum_nxt      = psum_r;
    tally_nxt     = tally_r;
    if (accept) begin
      if (in_command == CMD_HARVEST) begin
        hsum_nxt  = '0;
        psum_nxt  = '0;
        tally_nxt = '0;
      end else if (in_level == LVL_RISE) begin
        if (rise_seen_r) begin
          psum_nxt  = psum_r + {{(SUM_W-TS_W){1'b0}}, period_d};
          hsum_nxt  = hsum_r + {{(SUM_W-TS_W){1'b0}}, high_d};
          tally_nxt = tally_r + 1'b1;
        end
        last_rise_nxt = in_timestamp_us;
        rise_seen_nxt = 1'b1;
      end else begin
        last_fall_nxt = in_timestamp_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rise_r <= '0;
      last_fall_r <= '0;
      rise_seen_r <= 1'b0;
      hsum_r      <= '0;
      psum_r      <= '0;
      tally_r     <= '0;
    end else begin
      last_rise_r <= last_rise_nxt;
      last_fall_r <= last_fall_nxt;
      rise_seen_r <= rise_seen_nxt;
      hsum_r      <= hsum_nxt;
      psum_r      <= psum_nxt;
      tally_r     <= tally_nxt;
    end
  end

endmodule

### hw/rtl/pdcm_queue.sv
// pdcm_queue: small register queue of harvest jobs between front and divider
// depends on pdcm_pkg

module pdcm_queue
  import pdcm_pkg::*;
#(
  parameter int DEPTH = 2
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/pdcm_back.sv
// pdcm_back: shift-add scale by 10000, restoring divide, result register
// depends on pdcm_pkg

module pdcm_back
  import pdcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  job_t              q_job,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [DUTY_W-1:0] out_duty_hundredths,
  output logic              out_valid_res
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SUM_W-1:0]   h_r, h_nxt;
  logic [SUM_W-1:0]   p_r, p_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [SUM_W-1:0]   rem_r, rem_nxt;
  logic [DUTY_W-1:0]  nlo_r, nlo_nxt;
  logic [DUTY_W-1:0]  quo_r, quo_nxt;
  logic [3:0]         step_r, step_nxt;
  logic [DUTY_W-1:0]  pend_duty_r, pend_duty_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic               out_full_r, out_full_nxt;
  logic [DUTY_W-1:0]  out_duty_r;
  logic               out_valid_r;
  logic               out_load;
  logic [ACC_W-1:0]   term;
  logic [SUM_W:0]     rem_sh;
  logic [SUM_W:0]     rem_sub;
  logic               fits;

  assign term    = {{DUTY_W{1'b0}}, h_r} << mul_shift(step_r[2:0]);
  assign rem_sh  = {rem_r, nlo_r[DUTY_W-1]};
  assign fits    = (rem_sh >= {1'b0, p_r});
  assign rem_sub = rem_sh - {1'b0, p_r};

  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign out_load = (state_r == ST_HOLD) && (!out_full_r || out_pop);

  always_comb begin
    state_nxt      = state_r;
    h_nxt          = h_r;
    p_nxt          = p_r;
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    nlo_nxt        = nlo_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    pend_duty_nxt  = pend_duty_r;
    pend_valid_nxt = pend_valid_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          h_nxt    = q_job.high_sum;
          p_nxt    = q_job.period_sum;
          acc_nxt  = '0;
          step_nxt = '0;
          if (!q_job.ok) begin
            pend_duty_nxt  = '0;
            pend_valid_nxt = 1'b0;
            state_nxt      = ST_HOLD;
          end else if (q_job.high_sum >= q_job.period_sum) begin
            // high time at or above period saturates
            pend_duty_nxt  = DUTY_FULL;
            pend_valid_nxt = 1'b1;
            state_nxt      = ST_HOLD;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        acc_nxt  = acc_r + term;
        step_nxt = step_r + 1'b1;
        if (step_r[2:0] == MUL_STEPS - 1'b1) begin
          // 10000*h < p*2^14, so the top part is already below p
          rem_nxt   = acc_nxt[ACC_W-1:DUTY_W];
          nlo_nxt   = acc_nxt[DUTY_W-1:0];
          quo_nxt   = '0;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = fits ? rem_sub[SUM_W-1:0] : rem_sh[SUM_W-1:0];
        quo_nxt  = {quo_r[DUTY_W-2:0], fits};
        nlo_nxt  = {nlo_r[DUTY_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_STEPS - 1'b1) begin
          pend_duty_nxt  = quo_nxt;
          pend_valid_nxt = 1'b1;
          state_nxt      = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_full_nxt = out_full_r;
    if (out_load) begin
      out_full_nxt = 1'b1;
    end else if (out_pop && out_full_r) begin
      out_full_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    h_r          <= h_nxt;
    p_r          <= p_nxt;
    acc_r        <= acc_nxt;
    rem_r        <= rem_nxt;
    nlo_r        <= nlo_nxt;
    quo_r        <= quo_nxt;
    pend_duty_r  <= pend_duty_nxt;
    pend_valid_r <= pend_valid_nxt;
    if (out_load) begin
      out_duty_r  <= pend_duty_r;
      out_valid_r <= pend_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      step_r     <= '0;
      out_full_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      out_full_r <= out_full_nxt;
    end
  end

  assign out_empty           = !out_full_r;
  assign out_duty_hundredths = out_duty_r;
  assign out_valid_res       = out_valid_r;

`ifndef ASSERT_OFF
  // partial remainder stays below the divisor during the divide
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < p_r))
    else $error("divider remainder not below divisor");

  // a shown result never exceeds full scale
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_full_r |-> (out_duty_r <= DUTY_FULL))
    else $error("duty above full scale");

  // an invalid result carries zero duty
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_full_r && !out_valid_r) |-> (out_duty_r == '0))
    else $error("invalid result with nonzero duty");

  // a job is taken from the queue only when the divider goes busy
  a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r != ST_IDLE))
    else $error("job popped but divider stayed idle");
`endif

endmodule

### hw/rtl/pwm_duty_cycle_meter_top.sv
// pwm_duty_cycle_meter_top: top level of the pwm duty-cycle meter
// depends on pdcm_pkg, pdcm_front, pdcm_queue, pdcm_back
//
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------------
// in_      | in_push / in_full  | in_command, in_level, in_timestamp_us[31:0]
// out_     | out_pop / out_empty| out_duty_hundredths[13:0], out_valid_res
//
// an edge event updates the front's edge state and sums and makes no result
// a harvest snapshots the window sums and queues them; the divider runs a load,
// 5 shift-add steps for x10000, 14 restoring divide steps and a hand-off per
// harvest, and empty or saturated windows go from the load to the hand-off
// synchronous active-low reset clears all edge state, sums, queue and result flag
// in_full is high while the harvest queue is full; a pending result waits in the
// output register; the front keeps going, and the divider waits at its hand-off

module pwm_duty_cycle_meter_top
  import pdcm_pkg::*;
#(
  // harvest jobs buffered between front and divider, 2 to 32
  parameter int QUEUE_DEPTH = 2
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_command,
  input  logic              in_level,
  input  logic [TS_W-1:0]   in_timestamp_us,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [DUTY_W-1:0] out_duty_hundredths,
  output logic              out_valid_res
);

  // front to queue
  logic q_push;
  logic q_full;
  job_t push_job;
  // queue to divider
  logic q_pop;
  logic q_empty;
  job_t pop_job;

  pdcm_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_level        (in_level),
    .in_timestamp_us (in_timestamp_us),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_job           (push_job)
  );

  pdcm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  // transfer out happens when out_pop meets a full result register
  pdcm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_job               (pop_job),
    .q_pop               (q_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_duty_hundredths (out_duty_hundredths),
    .out_valid_res       (out_valid_res)
  );

endmodule

### tb/pdcm_checker.sv
// pdcm_checker: watches both channels of the pwm duty-cycle meter, predicts each harvest
// result and compares it with what the block hands out; depends on pdcm_pkg
`timescale 1ns / 1ps

module pdcm_checker
  import pdcm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic              in_command,
  input  logic              in_level,
  input  logic [TS_W-1:0]   in_timestamp_us,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic [DUTY_W-1:0] out_duty_hundredths,
  input  logic              out_valid_res,
  output int                fail_count,
  output int                exp_count
);

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              valid;
  } duty_res_t;

  duty_res_t          duty_q[$];
  logic [TS_W-1:0]    rise_ts;
  logic [TS_W-1:0]    fall_ts;
  logic               rise_seen;
  logic [SUM_W-1:0]   high_acc;
  logic [SUM_W-1:0]   period_acc;
  logic [TALLY_W-1:0] period_cnt;
  int                 fails = 0;

  // exact floor(10000 * high / period), saturated, on 128-bit vectors
  function automatic duty_res_t window_duty(input logic [SUM_W-1:0] hs,
                                            input logic [SUM_W-1:0] ps,
                                            input logic [TALLY_W-1:0] n);
    logic [127:0] scaled;
    duty_res_t    r;
    r.duty  = '0;
    r.valid = 1'b0;
    if (n != '0 && ps != '0) begin
      r.valid = 1'b1;
      if (hs >= ps) begin
        r.duty = DUTY_FULL;
      end else begin
        scaled = ({64'd0, hs} * {114'd0, DUTY_FULL}) / {64'd0, ps};
        r.duty = scaled[DUTY_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    logic [TS_W-1:0] period_dt;
    logic [TS_W-1:0] high_dt;
    duty_res_t       got;
    duty_res_t       want;
    if (!rst_n) begin
      rise_ts    = '0;
      fall_ts    = '0;
      rise_seen  = 1'b0;
      high_acc   = '0;
      period_acc = '0;
      period_cnt = '0;
      duty_q.delete();
    end else begin
      if (in_push && !in_full) begin
        if (in_command == CMD_HARVEST) begin
          duty_q.push_back(window_duty(high_acc, period_acc, period_cnt));
          high_acc   = '0;
          period_acc = '0;
          period_cnt = '0;
        end else if (in_level == LVL_RISE) begin
          if (rise_seen) begin
            period_dt  = in_timestamp_us - rise_ts;
            high_dt    = fall_ts - rise_ts;
            period_acc = period_acc + {{(SUM_W-TS_W){1'b0}}, period_dt};
            high_acc   = high_acc + {{(SUM_W-TS_W){1'b0}}, high_dt};
            period_cnt = period_cnt + 1'b1;
          end
          rise_ts   = in_timestamp_us;
          rise_seen = 1'b1;
        end else begin
          fall_ts = in_timestamp_us;
        end
      end
      if (out_pop && !out_empty) begin
        got.duty  = out_duty_hundredths;
        got.valid = out_valid_res;
        if (duty_q.size() == 0) begin
          fails++;
          $display("%0t pdcm_checker: unexpected result, expected none, actual duty %0d valid %0b",
                   $time, got.duty, got.valid);
        end else begin
          want = duty_q.pop_front();
          if (got.duty !== want.duty) begin
            fails++;
            $display("%0t pdcm_checker: duty_hundredths expected %0d actual %0d",
                     $time, want.duty, got.duty);
          end
          if (got.valid !== want.valid) begin
            fails++;
            $display("%0t pdcm_checker: valid_res expected %0b actual %0b",
                     $time, want.valid, got.valid);
          end
        end
      end
    end
    fail_count <= fails;
    exp_count  <= duty_q.size();
  end

endmodule

### tb/testbench.sv
// testbench: drives edge events and harvest commands into the pwm duty-cycle meter
// under several idle and stall patterns; depends on pdcm_pkg, pdcm_checker and the block
`timescale 1ns / 1ps

module testbench;
  import pdcm_pkg::*;

  // longest run of cycles without any transfer before the run is called hung
  localparam int STALL_LIMIT = 4000;
  // receiver hold-off used to fill the harvest queue and back up the input
  localparam int HOLD_CYCLES = 300;
  // cycles left after the last result, well above the divider latency
  localparam int TAIL_CYCLES = 50;
  localparam int PHASE_ITEMS = 450;
  localparam logic LVL_FALL  = ~LVL_RISE;

  logic              clk;
  logic              rst_n;
  logic              in_push;
  logic              in_full;
  logic              in_command;
  logic              in_level;
  logic [TS_W-1:0]   in_timestamp_us;
  logic              out_empty;
  logic              out_pop;
  logic [DUTY_W-1:0] out_duty_hundredths;
  logic              out_valid_res;

  int                fail_count;
  int                exp_count;

  // idle/stall odds in percent per cycle, set per phase
  int                send_idle_pct = 0;
  int                pop_stall_pct = 0;
  bit                hold_req = 1'b0;
  int                items_sent = 0;
  int                quiet_cycles = 0;
  // running pwm time; synced means the last edge was a rise at this time
  logic [TS_W-1:0]   pwm_now;
  bit                pwm_synced;

  pwm_duty_cycle_meter_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_command          (in_command),
    .in_level            (in_level),
    .in_timestamp_us     (in_timestamp_us),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_duty_hundredths (out_duty_hundredths),
    .out_valid_res       (out_valid_res)
  );

  pdcm_checker chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_command          (in_command),
    .in_level            (in_level),
    .in_timestamp_us     (in_timestamp_us),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_duty_hundredths (out_duty_hundredths),
    .out_valid_res       (out_valid_res),
    .fail_count          (fail_count),
    .exp_count           (exp_count)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // hang detector: any transfer on either side resets the count
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("pwm_duty_cycle_meter_top: mismatch");
      $finish;
    end
  end

  // result side: random pop per cycle, or a long counted hold-off on request
  initial begin : receiver
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_pop <= ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // offer one item and return at the edge where it transfers; push stays high
  // so a following call that does not idle keeps the channel busy without a gap
  task automatic send_item(input logic cmd, input logic lvl, input logic [TS_W-1:0] ts);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_push         <= 1'b1;
    in_command      <= cmd;
    in_level        <= lvl;
    in_timestamp_us <= ts;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  // sender goes quiet until every predicted result has been popped
  task automatic drain_results();
    in_push <= 1'b0;
    @(posedge clk);
    while (exp_count != 0) @(posedge clk);
  endtask

  // well-formed pwm: a few periods of random length and duty, then a harvest;
  // now and then a fall edge goes missing so the high time turns stale
  task automatic pwm_burst();
    int              periods;
    int              scale;
    logic [TS_W-1:0] per;
    logic [TS_W-1:0] hi;
    if (!pwm_synced) begin
      // fresh rise and harvest so noise does not leak into this window
      send_item(CMD_EDGE, LVL_RISE, pwm_now);
      send_item(CMD_HARVEST, 1'($urandom_range(1)), $urandom);
      pwm_synced = 1'b1;
    end
    periods = $urandom_range(6, 1);
    repeat (periods) begin
      scale = $urandom_range(9);
      // mostly short periods, some long, a few across the full 32-bit span
      if (scale < 6) per = $urandom_range(5000, 2);
      else if (scale < 9) per = $urandom_range(1 << 20, 1);
      else per = $urandom;
      hi = $urandom_range(per, 0);
      if ($urandom_range(9) != 0) send_item(CMD_EDGE, LVL_FALL, pwm_now + hi);
      pwm_now = pwm_now + per;
      send_item(CMD_EDGE, LVL_RISE, pwm_now);
    end
    send_item(CMD_HARVEST, 1'($urandom_range(1)), $urandom);
  endtask

  // broken sequences: random commands, levels and timestamps
  task automatic noise_burst();
    repeat ($urandom_range(4, 1)) begin
      send_item(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
    end
    pwm_now    = $urandom;
    pwm_synced = 1'b0;
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
    int stop_at;
    send_idle_pct = idle_pct;
    pop_stall_pct = stall_pct;
    stop_at       = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) == 0) noise_burst();
      else pwm_burst();
    end
    drain_results();
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    in_push         = 1'b0;
    in_command      = CMD_EDGE;
    in_level        = LVL_FALL;
    in_timestamp_us = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty window right after reset, harvest fields at extremes
    send_item(CMD_HARVEST, LVL_RISE, 32'hFFFF_FFFF);
    // first rise only arms the period, so the window is still empty
    send_item(CMD_EDGE, LVL_RISE, 32'd0);
    send_item(CMD_HARVEST, LVL_FALL, 32'd0);
    // one period of zero length: counted but the period sum stays zero
    send_item(CMD_EDGE, LVL_RISE, 32'd0);
    send_item(CMD_HARVEST, LVL_RISE, 32'd0);
    // plain quarter duty
    send_item(CMD_EDGE, LVL_FALL, 32'd250);
    send_item(CMD_EDGE, LVL_RISE, 32'd1000);
    send_item(CMD_HARVEST, LVL_FALL, 32'h5555_5555);
    // zero duty: fall on the rise time
    send_item(CMD_EDGE, LVL_FALL, 32'd1000);
    send_item(CMD_EDGE, LVL_RISE, 32'd2000);
    send_item(CMD_HARVEST, LVL_RISE, 32'hAAAA_AAAA);
    // high equals period, saturates
    send_item(CMD_EDGE, LVL_FALL, 32'd3000);
    send_item(CMD_EDGE, LVL_RISE, 32'd3000);
    send_item(CMD_HARVEST, LVL_FALL, 32'd0);
    // stale fall before the last rise: high wraps past the period
    send_item(CMD_EDGE, LVL_FALL, 32'd2500);
    send_item(CMD_EDGE, LVL_RISE, 32'd4000);
    send_item(CMD_HARVEST, LVL_RISE, 32'hFFFF_FFFF);
    // timestamps across the 32-bit wrap, long and tiny high times
    send_item(CMD_EDGE, LVL_RISE, 32'hFFFF_FF00);
    send_item(CMD_HARVEST, LVL_FALL, 32'd7);
    send_item(CMD_EDGE, LVL_FALL, 32'hFFFF_FFFF);
    send_item(CMD_EDGE, LVL_RISE, 32'h0000_0064);
    send_item(CMD_EDGE, LVL_FALL, 32'h0000_0065);
    send_item(CMD_EDGE, LVL_RISE, 32'hFFFF_FFFF);
    send_item(CMD_HARVEST, LVL_RISE, 32'h8000_0000);
    // harvest right after a harvest sees an empty window
    send_item(CMD_HARVEST, LVL_FALL, 32'h0000_0001);
    pwm_now    = 32'hFFFF_FFFF;
    pwm_synced = 1'b1;

    // back-pressure: receiver holds off while harvests keep coming, so the
    // queue fills and in_full stalls the sender; then a full pause to drain
    hold_req = 1'b1;
    repeat (8) begin
      pwm_now = pwm_now + $urandom_range(3000, 10);
      send_item(CMD_EDGE, LVL_RISE, pwm_now);
      send_item(CMD_HARVEST, 1'($urandom_range(1)), $urandom);
    end
    drain_results();

    // random phases: no idling, sender idle, receiver stalling, both
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(86, 0, PHASE_ITEMS);
    run_phase(0, 86, PHASE_ITEMS);
    run_phase(33, 33, PHASE_ITEMS);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("pwm_duty_cycle_meter_top: match");
    end else begin
      $display("pwm_duty_cycle_meter_top: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/pdcm_pkg.sv
hw/rtl/pdcm_front.sv
hw/rtl/pdcm_queue.sv
hw/rtl/pdcm_back.sv
hw/rtl/pwm_duty_cycle_meter_top.sv
tb/pdcm_checker.sv
tb/testbench.sv
